// File: rtl/plm_pkg.sv
`default_nettype none

package plm_pkg;

  // Defaults for the top-level parameters.
  localparam int DefMaxPoints = 16;
  localparam int DefDataWidth = 16;

  // Value of the points register after reset.
  localparam int PointsReset = 2;

  // Operation codes of an input word.
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK_FIRST,
    S_CHK_LAST,
    S_SCAN,
    S_MUL,
    S_DIV,
    S_FIN
  } state_t;

  // Source of the table read address.
  typedef enum logic [1:0] {
    ADDR_ZERO,
    ADDR_LAST,
    ADDR_NEXT
  } addr_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load_x;
    addr_sel_t addr_sel;
    logic      save_prev;
    logic      p_inc;
    logic      seg_load;
    logic      mul;
    logic      div_step;
    logic      fin_rd;
    logic      fin_interp;
  } cmd_t;

  // Compare results from the datapath to the controller.
  typedef struct packed {
    logic x_le;
    logic x_ge;
    logic x_eq;
    logic p_last;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/plm_ram.sv
`default_nettype none

module plm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/plm_ctrl.sv
`default_nettype none

module plm_ctrl #(
  parameter int DATA_WIDTH = plm_pkg::DefDataWidth
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             operation,
  input  wire plm_pkg::status_t status,
  output logic                  busy,
  output plm_pkg::cmd_t         cmd
);

  // The quotient has one bit more than the data.
  localparam int AccW = DATA_WIDTH + 1;
  localparam int CntW = $clog2(AccW);

  plm_pkg::state_t state, state_next;
  logic [CntW-1:0] cnt, cnt_next;

  // State and division step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plm_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign busy = (state != plm_pkg::S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      plm_pkg::S_IDLE: begin
        if (start && (operation == plm_pkg::OP_LOOKUP)) begin
          cmd.load_x   = 1'b1;
          cmd.addr_sel = plm_pkg::ADDR_ZERO;
          state_next   = plm_pkg::S_CHK_FIRST;
        end
      end
      plm_pkg::S_CHK_FIRST: begin
        if (status.x_le) begin
          cmd.fin_rd = 1'b1;
          state_next = plm_pkg::S_IDLE;
        end else begin
          cmd.save_prev = 1'b1;
          cmd.addr_sel  = plm_pkg::ADDR_LAST;
          state_next    = plm_pkg::S_CHK_LAST;
        end
      end
      plm_pkg::S_CHK_LAST: begin
        if (status.x_ge) begin
          cmd.fin_rd = 1'b1;
          state_next = plm_pkg::S_IDLE;
        end else begin
          cmd.p_inc    = 1'b1;
          cmd.addr_sel = plm_pkg::ADDR_NEXT;
          state_next   = plm_pkg::S_SCAN;
        end
      end
      plm_pkg::S_SCAN: begin
        if (!status.p_last && !status.x_le) begin
          cmd.save_prev = 1'b1;
          cmd.p_inc     = 1'b1;
          cmd.addr_sel  = plm_pkg::ADDR_NEXT;
        end else if (status.x_eq) begin
          cmd.fin_rd = 1'b1;
          state_next = plm_pkg::S_IDLE;
        end else begin
          cmd.seg_load = 1'b1;
          state_next   = plm_pkg::S_MUL;
        end
      end
      plm_pkg::S_MUL: begin
        cmd.mul    = 1'b1;
        cnt_next   = CntW'(AccW - 1);
        state_next = plm_pkg::S_DIV;
      end
      plm_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = plm_pkg::S_FIN;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      plm_pkg::S_FIN: begin
        cmd.fin_interp = 1'b1;
        state_next     = plm_pkg::S_IDLE;
      end
      default: begin
        state_next = plm_pkg::S_IDLE;
      end
    endcase
  end

  // An accepted lookup always makes the block busy.
  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    (!busy && start && (operation == plm_pkg::OP_LOOKUP)) |=> busy)
    else $error("lookup accepted but controller stayed idle");

  // The last division step always leads to the final add.
  a_div_end: assert property (@(posedge clk) disable iff (rst)
    (state == plm_pkg::S_DIV && cnt == '0) |=> (state == plm_pkg::S_FIN))
    else $error("division did not end after its last step");

endmodule

`default_nettype wire

// File: rtl/plm_dp.sv
`default_nettype none

module plm_dp #(
  parameter int MAX_POINTS = plm_pkg::DefMaxPoints,
  parameter int DATA_WIDTH = plm_pkg::DefDataWidth,
  localparam int IdxW = $clog2(MAX_POINTS),
  localparam int PtsW = $clog2(MAX_POINTS + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic                         busy,
  input  wire plm_pkg::cmd_t                cmd,
  output plm_pkg::status_t                  status,
  input  wire logic                         operation,
  input  wire logic        [IdxW-1:0]       entry_index,
  input  wire logic signed [DATA_WIDTH-1:0] breakpoint_in,
  input  wire logic signed [DATA_WIDTH-1:0] breakpoint_out,
  input  wire logic signed [DATA_WIDTH-1:0] lookup_value,
  input  wire logic                         cfg_wr_en,
  input  wire logic        [PtsW-1:0]       cfg_wr_data,
  output logic                              done,
  output logic signed      [DATA_WIDTH-1:0] mapped_value
);

  localparam int AccW = DATA_WIDTH + 1;

  logic [PtsW-1:0]               points;
  logic signed [DATA_WIDTH-1:0]  x;
  logic [IdxW-1:0]               n_last;
  logic [IdxW-1:0]               p;
  logic signed [DATA_WIDTH-1:0]  prev_in;
  logic signed [DATA_WIDTH-1:0]  prev_out;
  logic signed [DATA_WIDTH-1:0]  y0;
  logic [AccW-1:0]               dx;
  logic [AccW-1:0]               den;
  logic                          dy_neg;
  logic [AccW-1:0]               dy_mag;
  logic [AccW-1:0]               rem;
  logic [AccW-1:0]               lo;

  logic                          accept;
  logic                          wr_en;
  logic [IdxW-1:0]               n_last_next;
  logic [IdxW-1:0]               raddr;
  logic [2*DATA_WIDTH-1:0]       rdata;
  logic signed [DATA_WIDTH-1:0]  rd_in;
  logic signed [DATA_WIDTH-1:0]  rd_out;
  logic signed [AccW-1:0]        dx_full;
  logic signed [AccW-1:0]        den_full;
  logic signed [AccW-1:0]        dy_full;
  logic [2*AccW-1:0]             prod;
  logic [AccW:0]                 trial;
  logic                          q_bit;
  logic [AccW-1:0]               sum;

  assign accept = start && !busy;

  // Table writes happen in the accept cycle; indexes past the table are dropped.
  assign wr_en = accept && (operation == plm_pkg::OP_WRITE)
                 && ({1'b0, entry_index} < (IdxW + 1)'(MAX_POINTS));

  plm_ram #(
    .WIDTH (2 * DATA_WIDTH),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (entry_index),
    .wdata ({breakpoint_in, breakpoint_out}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_in  = rdata[2*DATA_WIDTH-1:DATA_WIDTH];
  assign rd_out = rdata[DATA_WIDTH-1:0];

  // Read address for the next cycle.
  always_comb begin
    unique case (cmd.addr_sel)
      plm_pkg::ADDR_ZERO: raddr = '0;
      plm_pkg::ADDR_LAST: raddr = n_last;
      plm_pkg::ADDR_NEXT: raddr = p + 1'b1;
      default:            raddr = '0;
    endcase
  end

  // Index of the last entry in use, with the count held to its legal range.
  always_comb begin
    if (points < PtsW'(2)) begin
      n_last_next = IdxW'(1);
    end else if (points > PtsW'(MAX_POINTS)) begin
      n_last_next = IdxW'(MAX_POINTS - 1);
    end else begin
      n_last_next = IdxW'(points - 1'b1);
    end
  end

  // Compares of the sample against the entry just read.
  assign status.x_le   = (x <= rd_in);
  assign status.x_ge   = (x >= rd_in);
  assign status.x_eq   = (x == rd_in);
  assign status.p_last = (p == n_last);

  // Segment differences, one bit wider than the data.
  assign dx_full  = AccW'(x) - AccW'(prev_in);
  assign den_full = AccW'(rd_in) - AccW'(prev_in);
  assign dy_full  = AccW'(rd_out) - AccW'(prev_out);

  assign prod = (2 * AccW)'(dx) * (2 * AccW)'(dy_mag);

  // One restoring division step: the quotient bits shift into lo.
  assign trial = {rem, lo[AccW-1]};
  assign q_bit = (trial >= {1'b0, den});

  assign sum = dy_neg ? (AccW'(y0) - lo) : (AccW'(y0) + lo);

  // Points register.
  always_ff @(posedge clk) begin
    if (rst) begin
      points <= PtsW'(plm_pkg::PointsReset);
    end else if (cfg_wr_en) begin
      points <= cfg_wr_data;
    end
  end

  // Search registers.
  always_ff @(posedge clk) begin
    if (cmd.load_x) begin
      x      <= lookup_value;
      n_last <= n_last_next;
      p      <= '0;
    end else if (cmd.p_inc) begin
      p <= p + 1'b1;
    end
    if (cmd.save_prev) begin
      prev_in  <= rd_in;
      prev_out <= rd_out;
    end
  end

  // Interpolation registers.
  always_ff @(posedge clk) begin
    if (cmd.seg_load) begin
      y0     <= prev_out;
      dx     <= dx_full;
      den    <= den_full;
      dy_neg <= dy_full[AccW-1];
      dy_mag <= dy_full[AccW-1] ? (AccW'(0) - dy_full) : dy_full;
    end
    if (cmd.mul) begin
      rem <= prod[2*AccW-1:AccW];
      lo  <= prod[AccW-1:0];
    end else if (cmd.div_step) begin
      rem <= q_bit ? AccW'(trial - {1'b0, den}) : trial[AccW-1:0];
      lo  <= {lo[AccW-2:0], q_bit};
    end
  end

  // Result word and its strobe.
  always_ff @(posedge clk) begin
    if (cmd.fin_rd) begin
      mapped_value <= rd_out;
    end else if (cmd.fin_interp) begin
      mapped_value <= sum[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.fin_rd || cmd.fin_interp;
    end
  end

  // A result word only follows a cycle of lookup work.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a lookup in progress");

  // The search never steps past the last entry in use.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.p_inc |-> !status.p_last)
    else $error("search pointer stepped past the last entry");

  // The partial remainder stays below the divisor during division.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (rem < den))
    else $error("division remainder not below divisor");

endmodule

`default_nettype wire

// File: rtl/piecewise_linear_map.sv
`default_nettype none

// Piecewise-linear map through a table of breakpoint pairs.
// An input word is taken when start is high and busy is low. With operation
// set to write, breakpoint_in and breakpoint_out are stored at entry_index in
// that same cycle; no result follows and busy stays low. With operation set
// to lookup, lookup_value is mapped and one result word appears on
// mapped_value, marked by done for exactly one cycle; the receiver cannot
// stall it. A lookup either clamps at the first or the last breakpoint, ends
// on an exact breakpoint found by the search, or interpolates (a multiply
// step plus DATA_WIDTH + 1 restoring division steps). The breakpoint search
// reads the single table read port once per cycle. Busy is high from the
// cycle after a lookup is accepted until done is raised, so the next word can
// be taken in the cycle that carries done. Register points is written with
// cfg_wr_en and cfg_wr_data; the user must write it only while the block is
// idle, which the block itself does not enforce. Reset sets points to 2 and
// returns to idle; the table keeps no reset value and must be written before
// it is read.
module piecewise_linear_map #(
  parameter int MAX_POINTS = plm_pkg::DefMaxPoints,
  parameter int DATA_WIDTH = plm_pkg::DefDataWidth,
  localparam int IdxW = $clog2(MAX_POINTS),
  localparam int PtsW = $clog2(MAX_POINTS + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         operation,
  input  wire logic        [IdxW-1:0]       entry_index,
  input  wire logic signed [DATA_WIDTH-1:0] breakpoint_in,
  input  wire logic signed [DATA_WIDTH-1:0] breakpoint_out,
  input  wire logic signed [DATA_WIDTH-1:0] lookup_value,
  input  wire logic                         cfg_wr_en,
  input  wire logic        [PtsW-1:0]       cfg_wr_data,
  output logic                              done,
  output logic signed      [DATA_WIDTH-1:0] mapped_value
);

  plm_pkg::cmd_t    cmd;
  plm_pkg::status_t status;

  // Sequencer for the search and the serial division.
  plm_ctrl #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .status    (status),
    .busy      (busy),
    .cmd       (cmd)
  );

  // Table, compares, multiplier and divider.
  plm_dp #(
    .MAX_POINTS (MAX_POINTS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .cmd            (cmd),
    .status         (status),
    .operation      (operation),
    .entry_index    (entry_index),
    .breakpoint_in  (breakpoint_in),
    .breakpoint_out (breakpoint_out),
    .lookup_value   (lookup_value),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .done           (done),
    .mapped_value   (mapped_value)
  );

endmodule

`default_nettype wire
